// File: rtl/assert_macros.svh
// Assertion macros shared by the channel slot picker RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CSFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CSFP_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// File: rtl/csfp_pkg.sv
// Shared types and constants for the channel slot frequency picker.
// No dependencies; imported by every module of the block.
package csfp_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned SlotW   = 17;
  localparam int unsigned BwW     = 19;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned ProdW   = SlotW + BwW;
  localparam int unsigned SumW    = ProdW + 1;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned DivCntW = $clog2(HashW);

  localparam logic [HashW-1:0] HashSeed = 32'd5381;
  localparam logic [SlotW-1:0] MaxSlots = 17'd96000;

  // register indexes
  localparam logic [2:0] RegBandStart = 3'd0;
  localparam logic [2:0] RegBandEnd   = 3'd1;
  localparam logic [2:0] RegBwCode    = 3'd2;
  localparam logic [2:0] RegRegionVld = 3'd3;
  localparam logic [2:0] RegFallback  = 3'd4;

  // bandwidth snap thresholds (midpoints between 31,62,125,250,500; tie goes low)
  localparam logic [15:0] Snap62  = 16'd47;
  localparam logic [15:0] Snap125 = 16'd94;
  localparam logic [15:0] Snap250 = 16'd188;
  localparam logic [15:0] Snap500 = 16'd376;

  localparam logic [BwW-1:0] Bw31Hz  = 19'd31250;
  localparam logic [BwW-1:0] Bw62Hz  = 19'd62500;
  localparam logic [BwW-1:0] Bw125Hz = 19'd125000;
  localparam logic [BwW-1:0] Bw250Hz = 19'd250000;
  localparam logic [BwW-1:0] Bw500Hz = 19'd500000;

  typedef struct packed {
    logic [FreqW-1:0] band_start_hz;
    logic [FreqW-1:0] band_end_hz;
    logic [15:0]      bandwidth_code;
    logic             region_valid;
    logic [FreqW-1:0] fallback_freq_hz;
  } cfg_t;

  typedef struct packed {
    logic             push;
    logic [HashW-1:0] hash;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic             start;
    logic [HashW-1:0] dividend;
    logic [HashW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] quot;
    logic [HashW-1:0] rem;
  } div_rsp_t;

  function automatic logic [BwW-1:0] snap_bw_hz(input logic [15:0] code);
    logic [BwW-1:0] bw;
    if (code < Snap62) begin
      bw = Bw31Hz;
    end else if (code < Snap125) begin
      bw = Bw62Hz;
    end else if (code < Snap250) begin
      bw = Bw125Hz;
    end else if (code < Snap500) begin
      bw = Bw250Hz;
    end else begin
      bw = Bw500Hz;
    end
    return bw;
  endfunction

endpackage

// File: rtl/csfp_front.sv
// Front end: accepts name bytes and runs the djb2 hash, one byte per cycle while the queue is not full.
// Depends on csfp_pkg; pushes finished hashes into csfp_fifo.
module csfp_front import csfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] name_byte_i,
  input  logic       no_byte_i,
  input  logic       last_i,
  input  q_stat_t    q_stat_i,
  output q_wr_t      q_wr_o
);

  logic [HashW-1:0] hash_q, hash_d, hash_upd;
  logic             accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // h*33 + b as shift-add
  assign hash_upd = {hash_q[HashW-6:0], 5'b0} + hash_q + {{(HashW-8){1'b0}}, name_byte_i};

  always_comb begin
    q_wr_o.hash = no_byte_i ? hash_q : hash_upd;
    q_wr_o.push = accept && last_i;
    hash_d      = hash_q;
    if (accept) begin
      hash_d = last_i ? HashSeed : q_wr_o.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashSeed;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// File: rtl/csfp_fifo.sv
// Short hash queue between front and back ends.
// Depends on csfp_pkg and assert_macros.svh.
module csfp_fifo import csfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_wr_t            wr_i,
  input  logic             pop_i,
  output logic [HashW-1:0] rd_hash_o,
  output q_stat_t          stat_o
);

  `include "assert_macros.svh"

  logic [HashW-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign do_pop       = pop_i && !stat_o.empty;
  assign rd_hash_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_i.push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_i.push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `CSFP_NEVER(a_no_push_full, clk_i, rst_ni, wr_i.push && stat_o.full, "push into full queue")

endmodule

// File: rtl/csfp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on csfp_pkg and assert_macros.svh.
module csfp_div import csfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  `include "assert_macros.svh"

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [HashW-1:0]   quo_q, rem_q, dvs_q;
  logic [HashW:0]     rem_sh, rem_sub;

  assign rem_sh  = {rem_q, quo_q[HashW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!rem_sub[HashW]) begin
        rem_q <= rem_sub[HashW-1:0];
        quo_q <= {quo_q[HashW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[HashW-1:0];
        quo_q <= {quo_q[HashW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !req_i.start && (cnt_q == DivCntW'(HashW - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(HashW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  `CSFP_NEVER(a_start_idle, clk_i, rst_ni, req_i.start && busy_q, "divider restarted while busy")

endmodule

// File: rtl/csfp_back.sv
// Back end: slot count, hash modulo count, centre frequency, output register.
// Depends on csfp_pkg, csfp_div and assert_macros.svh.
module csfp_back import csfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  q_stat_t          q_stat_i,
  input  logic [HashW-1:0] q_hash_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SlotW-1:0] slot_o,
  output logic [FreqW-1:0] freq_hz_o,
  output logic [SlotW-1:0] slot_count_o,
  output logic             used_fallback_o
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    StIdle,
    StCount,
    StSlot,
    StMul,
    StOut
  } state_e;

  state_e           state_q;
  logic [HashW-1:0] hash_q;
  logic [SlotW-1:0] count_q, slot_q;
  logic [ProdW-1:0] prod_q;
  logic             fb_q;
  logic             out_valid_q, out_fb_q;
  logic [SlotW-1:0] out_slot_q, out_count_q;
  logic [FreqW-1:0] out_freq_q;

  logic [BwW-1:0]   bw;
  logic [FreqW-1:0] span;
  logic [SlotW-1:0] count_sat;
  logic [SumW-1:0]  freq_sum;
  logic [FreqW-1:0] freq_sat;
  logic             out_free;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign bw   = snap_bw_hz(cfg_i.bandwidth_code);
  assign span = (cfg_i.band_end_hz > cfg_i.band_start_hz) ?
                (cfg_i.band_end_hz - cfg_i.band_start_hz) : '0;

  // count clamps to [1, MaxSlots]
  always_comb begin
    if (div_rsp.quot == '0) begin
      count_sat = SlotW'(1);
    end else if (div_rsp.quot > {{(HashW-SlotW){1'b0}}, MaxSlots}) begin
      count_sat = MaxSlots;
    end else begin
      count_sat = div_rsp.quot[SlotW-1:0];
    end
  end

  assign freq_sum = {{(SumW-FreqW){1'b0}}, cfg_i.band_start_hz}
                  + {{(SumW-BwW){1'b0}}, bw >> 1}
                  + {1'b0, prod_q};
  assign freq_sat = (freq_sum[SumW-1:FreqW] != '0) ? '1 : freq_sum[FreqW-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == StIdle) && !q_stat_i.empty;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = span;
    div_req.divisor  = {{(HashW-BwW){1'b0}}, bw};
    case (state_q)
      StIdle: begin
        div_req.start = !q_stat_i.empty && cfg_i.region_valid;
      end
      StCount: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = hash_q;
        div_req.divisor  = {{(HashW-SlotW){1'b0}}, count_sat};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  csfp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      hash_q      <= '0;
      count_q     <= '0;
      slot_q      <= '0;
      prod_q      <= '0;
      fb_q        <= 1'b0;
      out_fb_q    <= 1'b0;
      out_slot_q  <= '0;
      out_count_q <= '0;
      out_freq_q  <= '0;
    end else begin
      // in StOut the load below decides the valid bit
      if (out_valid_q && out_ready_i && (state_q != StOut)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!q_stat_i.empty) begin
            hash_q <= q_hash_i;
            if (cfg_i.region_valid) begin
              fb_q    <= 1'b0;
              state_q <= StCount;
            end else begin
              fb_q    <= 1'b1;
              slot_q  <= '0;
              count_q <= '0;
              state_q <= StOut;
            end
          end
        end
        StCount: begin
          if (div_rsp.done) begin
            count_q <= count_sat;
            state_q <= StSlot;
          end
        end
        StSlot: begin
          if (div_rsp.done) begin
            slot_q  <= div_rsp.rem[SlotW-1:0];
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= ProdW'(slot_q) * ProdW'(bw);
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_fb_q    <= fb_q;
            out_slot_q  <= slot_q;
            out_count_q <= count_q;
            out_freq_q  <= fb_q ? cfg_i.fallback_freq_hz : freq_sat;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_o          = out_slot_q;
  assign freq_hz_o       = out_freq_q;
  assign slot_count_o    = out_count_q;
  assign used_fallback_o = out_fb_q;

  `CSFP_ASSERT(a_slot_in_range, clk_i, rst_ni,
               (out_valid_q && !out_fb_q) |-> (out_slot_q < out_count_q),
               "slot not below slot count")
  `CSFP_ASSERT(a_fallback_zero, clk_i, rst_ni,
               (out_valid_q && out_fb_q) |-> (out_slot_q == '0 && out_count_q == '0),
               "fallback result with nonzero slot or count")

endmodule

// File: rtl/channel_slot_frequency_picker_core.sv
// Channel slot frequency picker: djb2 hash of a channel name mapped onto a band slot.
// Depends on csfp_pkg, csfp_front, csfp_fifo and csfp_back.
//
// The channel name enters one byte per word on the slave stream; a word with
// tuser set carries no byte, and the word with tlast set closes the name
// (tlast with tuser set closes it without adding a byte). Bytes are hashed
// djb2 style (seed 5381, h = h*33 + byte, 32-bit wrap) at one word per cycle
// while the queue has room. When a name closes, its hash drops into a
// four-entry queue and the hash restarts at the seed, so the next name streams
// in while the back end works. The back end turns each hash into one result
// word: slot count = (end - start) / bw clamped to 1..96000, where bw is the
// bandwidth code snapped to the nearest of 31, 62, 125, 250, 500 (ties to the
// lower; 31 and 62 mean 31250 Hz and 62500 Hz, others code*1000 Hz); slot =
// hash mod count; freq = start + bw/2 + slot*bw, saturating at 2^32-1. With
// region_valid clear the result is the fallback frequency with slot and count
// zero and tuser set. For each name the back end makes two passes through the
// shared bit-serial divider, one multiply and one output load; the fallback
// path goes straight to the output load. The slave side stalls only when four
// finished names are waiting. The result sits in an output register until
// taken. Configuration words (index 0..4 in register order, unknown indexes
// ignored) are always accepted and are meant to change only while the block
// has nothing in flight.
module channel_slot_frequency_picker_core import csfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // name stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] name_byte
  input  logic        s_axis_tuser,   // [0] no_byte
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [16:0] slot, [48:17] freq_hz,
                                      // [65:49] slot_count, [71:66] zero
  output logic        m_axis_tuser,   // [0] used_fallback
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t             cfg_q;
  q_wr_t            q_wr;
  q_stat_t          q_stat;
  logic [HashW-1:0] q_hash;
  logic             q_pop;
  logic [SlotW-1:0] slot, slot_count;
  logic [FreqW-1:0] freq_hz;

  // config registers, reset to the default band
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_start_hz    <= 32'd902000000;
      cfg_q.band_end_hz      <= 32'd928000000;
      cfg_q.bandwidth_code   <= 16'd250;
      cfg_q.region_valid     <= 1'b1;
      cfg_q.fallback_freq_hz <= 32'd906875000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegBandStart: cfg_q.band_start_hz    <= cfg_data_i;
        RegBandEnd:   cfg_q.band_end_hz      <= cfg_data_i;
        RegBwCode:    cfg_q.bandwidth_code   <= cfg_data_i[15:0];
        RegRegionVld: cfg_q.region_valid     <= cfg_data_i[0];
        RegFallback:  cfg_q.fallback_freq_hz <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  csfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .name_byte_i(s_axis_tdata),
    .no_byte_i  (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .q_stat_i   (q_stat),
    .q_wr_o     (q_wr)
  );

  csfp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .pop_i    (q_pop),
    .rd_hash_o(q_hash),
    .stat_o   (q_stat)
  );

  csfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_stat_i       (q_stat),
    .q_hash_i       (q_hash),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .slot_o         (slot),
    .freq_hz_o      (freq_hz),
    .slot_count_o   (slot_count),
    .used_fallback_o(m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, slot_count, freq_hz, slot};

endmodule
